// ----- rtl/cpd_pkg.sv -----
`timescale 1ns / 1ps

package cpd_pkg;

  localparam int CODE_W            = 8;
  localparam int SLOTS             = 4;
  localparam int COUNT_W           = 3;
  localparam int MASK_W            = 4;
  localparam int NIBBLE_W          = 4;
  localparam int MAP_DEPTH_DEFAULT = 256;

  localparam logic [NIBBLE_W-1:0] CONTINUE_NIBBLE = 4'hF;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_START  = 2'd1,
    OP_SYMBOL = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  // One input transfer, as held in the input register.
  typedef struct packed {
    logic [1:0]                    operation;
    logic [CODE_W-1:0]             map_index;
    logic [CODE_W-1:0]             map_value;
    logic [MASK_W-1:0]             pixel_mask;
    logic                          raw_mode;
    logic [SLOTS-1:0][CODE_W-1:0]  prev_value;
    logic [CODE_W-1:0]             symbol;
  } item_t;

  // Finished cell handed from the cell controller to the map lookup stage.
  typedef struct packed {
    logic [SLOTS-1:0][CODE_W-1:0]  code;
    logic [SLOTS-1:0]              from_map;
    logic [SLOTS-1:0][CODE_W-1:0]  prev;
    logic [COUNT_W-1:0]            count;
  } finish_t;

endpackage

// ----- rtl/cpd_ram.sv -----
`timescale 1ns / 1ps

module cpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/cpd_cell_ctrl.sv -----
`timescale 1ns / 1ps

module cpd_cell_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_live,
  input  cpd_pkg::item_t   item,
  input  logic             advance,
  output logic             produce,
  output cpd_pkg::finish_t fin
);

  localparam int CW = cpd_pkg::CODE_W;
  localparam int NS = cpd_pkg::SLOTS;
  localparam int KW = cpd_pkg::COUNT_W;

  logic [NS-1:0][CW-1:0] code_stack;
  logic [CW-1:0]         last_code;
  logic [CW-1:0]         partial_code;
  logic [KW-1:0]         decoded_count;
  logic [KW-1:0]         expected_count;
  logic [cpd_pkg::MASK_W-1:0] cell_mask;
  logic                  cell_raw;
  logic [NS-1:0][CW-1:0] previous_entry;
  logic                  cell_busy;

  logic [cpd_pkg::NIBBLE_W-1:0] step;
  logic [CW-1:0]         part_sum;
  logic [CW-1:0]         code;
  logic                  is_start;
  logic                  is_sym;
  logic                  is_cont;
  logic                  is_rep;
  logic                  push;
  logic                  done;
  logic                  start_zero;
  logic [KW-1:0]         count_inc;
  logic [KW-1:0]         fin_count;
  logic [KW-1:0]         mask_pop;
  logic [NS-1:0][CW-1:0] stack_next;

  assign step      = item.symbol[cpd_pkg::NIBBLE_W-1:0];
  assign part_sum  = partial_code + {{(CW - cpd_pkg::NIBBLE_W){1'b0}}, step};
  assign code      = cell_raw ? item.symbol : part_sum;
  assign is_start  = (item.operation == cpd_pkg::OP_START);
  assign is_sym    = (item.operation == cpd_pkg::OP_SYMBOL) && cell_busy;
  assign is_cont   = !cell_raw && (step == cpd_pkg::CONTINUE_NIBBLE);
  assign is_rep    = (code == last_code);
  assign push      = is_sym && !is_cont && !is_rep;
  assign count_inc = decoded_count + KW'(1);
  assign done      = is_sym && !is_cont && (is_rep || (count_inc >= expected_count));
  assign start_zero = is_start && (item.pixel_mask == '0);
  assign produce   = item_live && (done || start_zero);
  assign fin_count = push ? count_inc : decoded_count;

  assign mask_pop = KW'(item.pixel_mask[0]) + KW'(item.pixel_mask[1])
                  + KW'(item.pixel_mask[2]) + KW'(item.pixel_mask[3]);

  always_comb begin
    stack_next = code_stack;
    if (push && (decoded_count < KW'(NS))) begin
      stack_next[decoded_count[1:0]] = code;
    end
  end

  // Pop codes last-first into the set slots, lowest slot first.
  always_comb begin
    logic [KW-1:0] idx;
    logic [KW-1:0] idx_dec;
    idx     = fin_count;
    idx_dec = '0;
    fin     = '0;
    if (is_start) begin
      fin.prev  = item.prev_value;
      fin.count = '0;
    end else begin
      fin.prev  = previous_entry;
      fin.count = fin_count;
      for (int i = 0; i < NS; i++) begin
        if (cell_mask[i]) begin
          fin.from_map[i] = 1'b1;
          if (idx != '0) begin
            idx_dec     = idx - KW'(1);
            fin.code[i] = stack_next[idx_dec[1:0]];
            idx         = idx_dec;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_stack     <= '0;
      last_code      <= '0;
      partial_code   <= '0;
      decoded_count  <= '0;
      expected_count <= '0;
      cell_mask      <= '0;
      cell_raw       <= 1'b0;
      previous_entry <= '0;
      cell_busy      <= 1'b0;
    end else if (item_live && advance) begin
      if (is_start) begin
        cell_mask      <= item.pixel_mask;
        cell_raw       <= item.raw_mode;
        previous_entry <= item.prev_value;
        code_stack     <= '0;
        last_code      <= '0;
        partial_code   <= '0;
        decoded_count  <= '0;
        expected_count <= mask_pop;
        cell_busy      <= (item.pixel_mask != '0);
      end else if (is_sym) begin
        if (!cell_raw) begin
          partial_code <= part_sum;
        end
        if (!is_cont) begin
          if (is_rep) begin
            cell_busy <= 1'b0;
          end else begin
            code_stack    <= stack_next;
            decoded_count <= count_inc;
            last_code     <= code;
            partial_code  <= code;
            if (count_inc >= expected_count) begin
              cell_busy <= 1'b0;
            end
          end
        end
      end
    end
  end

  // An open cell always has codes still to come.
  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    cell_busy |-> (decoded_count < expected_count) && (expected_count <= KW'(NS)))
    else $error("open cell with no codes left to decode");

  // A symbol only finishes a cell that is open.
  a_sym_needs_cell: assert property (@(posedge clk) disable iff (rst)
    produce && (item.operation == cpd_pkg::OP_SYMBOL) |-> cell_busy)
    else $error("symbol finished a cell that was not open");

endmodule

// ----- rtl/cpd_map_lookup.sv -----
`timescale 1ns / 1ps

module cpd_map_lookup #(
  parameter int MAP_DEPTH = cpd_pkg::MAP_DEPTH_DEFAULT,
  localparam int MAP_AW   = $clog2(MAP_DEPTH)
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         wr_en,
  input  logic [MAP_AW-1:0]                            wr_addr,
  input  logic [cpd_pkg::CODE_W-1:0]                   wr_data,
  input  logic                                         capture,
  input  cpd_pkg::finish_t                             fin,
  output logic [cpd_pkg::SLOTS-1:0][cpd_pkg::CODE_W-1:0] entry,
  output logic [cpd_pkg::COUNT_W-1:0]                  count
);

  localparam int CW  = cpd_pkg::CODE_W;
  localparam int NS  = cpd_pkg::SLOTS;
  localparam int CW1 = CW + 1;

  logic [MAP_DEPTH-1:0]  map_valid;
  logic [NS-1:0][CW-1:0] rd_data;
  logic [NS-1:0]         hit_r;
  logic [NS-1:0]         from_map_r;
  logic [NS-1:0][CW-1:0] prev_r;
  logic [NS-1:0]         in_range;

  // Map entries never loaded since reset read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      map_valid <= '0;
    end else if (wr_en) begin
      map_valid[wr_addr] <= 1'b1;
    end
  end

  // One map copy per slot so all four colours come out together.
  for (genvar g = 0; g < NS; g++) begin : g_slot
    assign in_range[g] = ({1'b0, fin.code[g]} < CW1'(MAP_DEPTH));

    cpd_ram #(
      .WIDTH (CW),
      .DEPTH (MAP_DEPTH)
    ) u_map (
      .clk     (clk),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (capture),
      .rd_addr (fin.code[g][MAP_AW-1:0]),
      .rd_data (rd_data[g])
    );

    assign entry[g] = from_map_r[g] ? (hit_r[g] ? rd_data[g] : '0) : prev_r[g];
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      for (int i = 0; i < NS; i++) begin
        hit_r[i] <= in_range[i] && map_valid[fin.code[i][MAP_AW-1:0]];
      end
      from_map_r <= fin.from_map;
      prev_r     <= fin.prev;
      count      <= fin.count;
    end
  end

endmodule

// ----- rtl/cell_palette_entry_decoder_top.sv -----
`timescale 1ns / 1ps
// Cell palette entry decoder.
// Input channel (item_valid / item_stall) carries one operation per transfer:
//   load map entry (map_index, map_value), start cell (pixel_mask, raw_mode,
//   prev_value_0..3) or code symbol (symbol). Output channel
//   (result_valid / result_stall) carries one finished entry per cell:
//   entry_value_0..3 and codes_decoded.
// Throughput: one input transfer per cycle, every operation type, while
//   item_stall is low. The input register feeds short decode logic; the
//   finishing item issues the four map reads (one map copy per slot) and
//   the registered read data forms the result stage.
// Path: a finishing item sits in the input register; once the result
//   stage is free, its map reads and cell data go into its registers.
// Stall: while a result waits, the block keeps accepting items that do not
//   finish a cell (loads, symbols, non-zero-mask starts). An item that would
//   finish a cell waits in the input register and item_stall rises.
// Reset: all cell state clears, the block is idle, and every map entry
//   reads as zero until loaded (per-entry valid flags, cleared at reset,
//   no clearing pass).
// Loads beyond MAP_DEPTH are dropped; codes beyond it map to zero.

module cell_palette_entry_decoder_top #(
  parameter int MAP_DEPTH = cpd_pkg::MAP_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] operation,
  input  logic [7:0] map_index,
  input  logic [7:0] map_value,
  input  logic [3:0] pixel_mask,
  input  logic       raw_mode,
  input  logic [7:0] prev_value_0,
  input  logic [7:0] prev_value_1,
  input  logic [7:0] prev_value_2,
  input  logic [7:0] prev_value_3,
  input  logic [7:0] symbol,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] entry_value_0,
  output logic [7:0] entry_value_1,
  output logic [7:0] entry_value_2,
  output logic [7:0] entry_value_3,
  output logic [2:0] codes_decoded
);

  localparam int CW     = cpd_pkg::CODE_W;
  localparam int CW1    = CW + 1;
  localparam int MAP_AW = $clog2(MAP_DEPTH);

  // Input register
  cpd_pkg::item_t   item_r;
  logic             item_live;
  logic             item_fire;
  logic             item_take;

  // Decode results
  logic             produce;
  cpd_pkg::finish_t fin;
  logic             res_ready;
  logic             capture;
  logic             map_wr;

  logic [cpd_pkg::SLOTS-1:0][CW-1:0] entry;

  // Result stage is free when empty or when its result transfers now.
  assign res_ready = !result_valid || !result_stall;
  // Item in the input register retires unless it finishes a cell and the
  // result stage is full.
  assign item_fire = item_live && (!produce || res_ready);
  assign item_stall = item_live && !item_fire;
  assign item_take  = item_valid && !item_stall;
  assign capture    = item_fire && produce;
  assign map_wr     = item_fire && (item_r.operation == cpd_pkg::OP_LOAD)
                   && ({1'b0, item_r.map_index} < CW1'(MAP_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      item_live <= 1'b0;
    end else if (item_take) begin
      item_live <= 1'b1;
    end else if (item_fire) begin
      item_live <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      item_r.operation     <= operation;
      item_r.map_index     <= map_index;
      item_r.map_value     <= map_value;
      item_r.pixel_mask    <= pixel_mask;
      item_r.raw_mode      <= raw_mode;
      item_r.prev_value[0] <= prev_value_0;
      item_r.prev_value[1] <= prev_value_1;
      item_r.prev_value[2] <= prev_value_2;
      item_r.prev_value[3] <= prev_value_3;
      item_r.symbol        <= symbol;
    end
  end

  cpd_cell_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_live (item_live),
    .item      (item_r),
    .advance   (item_fire),
    .produce   (produce),
    .fin       (fin)
  );

  cpd_map_lookup #(
    .MAP_DEPTH (MAP_DEPTH)
  ) u_lookup (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (map_wr),
    .wr_addr (item_r.map_index[MAP_AW-1:0]),
    .wr_data (item_r.map_value),
    .capture (capture),
    .fin     (fin),
    .entry   (entry),
    .count   (codes_decoded)
  );

  // Result valid flag; payload lives in the lookup stage registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_ready) begin
      result_valid <= capture;
    end
  end

  assign entry_value_0 = entry[0];
  assign entry_value_1 = entry[1];
  assign entry_value_2 = entry[2];
  assign entry_value_3 = entry[3];

  // The input register only holds back when a finished cell meets a full,
  // stalled result stage.
  a_hold_reason: assert property (@(posedge clk) disable iff (rst)
    item_live && !item_fire |-> produce && result_valid && result_stall)
    else $error("input register held without a stalled result");

  // Each finishing item yields exactly one result.
  a_capture_result: assert property (@(posedge clk) disable iff (rst)
    capture |=> result_valid)
    else $error("finished cell produced no result");

endmodule
